FILE: hdl/cdsb_pkg.sv
package cdsb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 40;
    localparam int ACC_W      = 48;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int COEF_DEPTH = 64;
    localparam int COEF_AW    = 6;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SH   = 16;

    // Line buffer depth and largest kernel side
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 8;
    localparam int WIN_W      = MAX_KERNEL * MAX_KERNEL * SAMPLE_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE   = 3'd5;

    // Input opcodes
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic signed [ACC_W-1:0] SUM_MAX = 48'sd549755813887;
    localparam logic signed [ACC_W-1:0] SUM_MIN = -48'sd549755813888;

    typedef struct packed {
        logic                       op;
        logic [COEF_AW-1:0]         coef_index;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last;
    } job_meta_t;

    typedef struct packed {
        logic [3:0]              kr;
        logic [3:0]              kc;
        logic signed [SUM_W-1:0] bias;
    } kcfg_t;

    typedef struct packed {
        logic                       we;
        logic [COEF_AW-1:0]         addr;
        logic signed [SAMPLE_W-1:0] data;
    } coef_wr_t;

    typedef enum logic [1:0] {F_IDLE, F_RD, F_DIV, F_CHK} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN} back_state_t;

    // ceil(2^16 / d): exact floor division for 12-bit dividends, d in 1..15
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            4'd10:   m = 17'd6554;
            4'd11:   m = 17'd5958;
            4'd12:   m = 17'd5462;
            4'd13:   m = 17'd5042;
            4'd14:   m = 17'd4682;
            4'd15:   m = 17'd4370;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/conv2d_stride_bias_stream_top.sv
// Pixel transaction: the front end does the line buffer read, window update, stride
// divide and grid check before it takes the next one, and waits while the queue is full.
// Results: each queued job runs through the back end, on the single multiply-accumulate
// unit stepping one kernel position per cycle.
// Coefficient transaction: taken once queued windows are finished.
// Reset (aresetn low, synchronous): registers to defaults, counters and window cleared.
module conv2d_stride_bias_stream_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cdsb_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cdsb_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cdsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdsb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int WIN_W = cdsb_pkg::WIN_W;
    localparam int META_W = $bits(cdsb_pkg::job_meta_t);

    cdsb_pkg::coef_wr_t  coef_wr;
    cdsb_pkg::kcfg_t     kcfg;
    cdsb_pkg::job_meta_t push_meta, head_meta;
    logic [WIN_W-1:0]    push_win, head_win;
    logic                push, pop, q_empty, q_full, back_busy;
    logic [cdsb_pkg::COEF_AW-1:0]  coef_raddr;
    logic [cdsb_pkg::SAMPLE_W-1:0] coef_rdata;

    cdsb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef_wr   (coef_wr),
        .kcfg      (kcfg),
        .push      (push),
        .push_meta (push_meta),
        .push_win  (push_win),
        .q_empty   (q_empty),
        .q_full    (q_full),
        .back_busy (back_busy)
    );

    cdsb_queue #(
        .WIDTH (META_W + WIN_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_meta, push_win}),
        .pop       (pop),
        .head_data ({head_meta, head_win}),
        .empty     (q_empty),
        .full      (q_full)
    );

    cdsb_ram #(
        .WIDTH (cdsb_pkg::SAMPLE_W),
        .DEPTH (cdsb_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_wr.we),
        .waddr (coef_wr.addr),
        .wdata (coef_wr.data),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    cdsb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .kcfg       (kcfg),
        .q_empty    (q_empty),
        .head_meta  (head_meta),
        .head_win   (head_win),
        .pop        (pop),
        .back_busy  (back_busy),
        .coef_raddr (coef_raddr),
        .coef_rdata (coef_rdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: hdl/cdsb_ram.sv
module cdsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/cdsb_queue.sv
module cdsb_queue #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/cdsb_front.sv
module cdsb_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  cdsb_pkg::in_item_t                     s_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cdsb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cdsb_pkg::CFG_DATA_W-1:0]        cfg_data,
    output cdsb_pkg::coef_wr_t                     coef_wr,
    output cdsb_pkg::kcfg_t                        kcfg,
    output logic                                   push,
    output cdsb_pkg::job_meta_t                    push_meta,
    output logic [cdsb_pkg::WIN_W-1:0]             push_win,
    input  logic                                   q_empty,
    input  logic                                   q_full,
    input  logic                                   back_busy
);

    localparam int MAX_WIDTH  = cdsb_pkg::MAX_WIDTH;
    localparam int MAX_KERNEL = cdsb_pkg::MAX_KERNEL;
    localparam int SW    = cdsb_pkg::SAMPLE_W;
    localparam int LB_AW = $clog2(MAX_WIDTH);
    localparam int LB_W  = SW * (MAX_KERNEL - 1);
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
    localparam logic [4:0]  MK5    = 5'(MAX_KERNEL);
    localparam logic [12:0] MAXH13 = 13'd4096;

    cdsb_pkg::front_state_t state_reg, state_next;

    logic [10:0] iw_reg, iw_next;
    logic [12:0] ih_reg, ih_next;
    logic [3:0]  kr_reg, kr_next;
    logic [3:0]  kc_reg, kc_next;
    logic [3:0]  st_reg, st_next;
    logic signed [cdsb_pkg::SUM_W-1:0] bias_reg, bias_next;

    logic [cdsb_pkg::ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [cdsb_pkg::COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic signed [SW-1:0]       sample_reg, sample_next;
    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SW-1:0] win_reg, win_next;

    logic [11:0] dr_reg, dr_next, dc_reg, dc_next;
    logic [11:0] eh_reg, eh_next, ew_reg, ew_next;
    logic [11:0] qr_reg, qr_next, qc_reg, qc_next;
    logic [11:0] qh_reg, qh_next, qw_reg, qw_next;
    logic        hit_reg, hit_next;

    logic [12:0] w_eff, h_eff;
    logic [3:0]  kr_eff, kc_eff, st_eff;
    logic [12:0] row13, col13, kr13, kc13, dr13, dc13, eh13, ew13, col_inc, row_inc;
    logic        cond;
    logic [cdsb_pkg::RECIP_W-1:0] m;
    logic        rem_ok;

    logic [LB_AW-1:0] lb_addr;
    logic [LB_W-1:0]  lb_rdata, lb_wdata;
    logic             lb_we;
    logic [MAX_KERNEL-1:0][SW-1:0] colv;

    // Clamp configuration to usable ranges
    always_comb begin
        if (iw_reg == 11'd0) begin
            w_eff = 13'd1;
        end else if ({2'b0, iw_reg} > MAXW13) begin
            w_eff = MAXW13;
        end else begin
            w_eff = {2'b0, iw_reg};
        end
        if (ih_reg == 13'd0) begin
            h_eff = 13'd1;
        end else if (ih_reg > MAXH13) begin
            h_eff = MAXH13;
        end else begin
            h_eff = ih_reg;
        end
        if (kr_reg == 4'd0) begin
            kr_eff = 4'd1;
        end else if ({1'b0, kr_reg} > MK5) begin
            kr_eff = MK5[3:0];
        end else begin
            kr_eff = kr_reg;
        end
        if (kc_reg == 4'd0) begin
            kc_eff = 4'd1;
        end else if ({1'b0, kc_reg} > MK5) begin
            kc_eff = MK5[3:0];
        end else begin
            kc_eff = kc_reg;
        end
        st_eff = (st_reg == 4'd0) ? 4'd1 : st_reg;
    end

    assign kcfg.kr   = kr_eff;
    assign kcfg.kc   = kc_eff;
    assign kcfg.bias = bias_reg;

    // Position arithmetic for the pixel in flight
    always_comb begin
        row13   = {1'b0, row_cnt_reg};
        col13   = {3'b0, col_cnt_reg};
        kr13    = {9'b0, kr_eff};
        kc13    = {9'b0, kc_eff};
        dr13    = row13 + 13'd1 - kr13;
        dc13    = col13 + 13'd1 - kc13;
        eh13    = h_eff - kr13;
        ew13    = w_eff - kc13;
        col_inc = col13 + 13'd1;
        row_inc = row13 + 13'd1;
        cond    = (row13 < h_eff) && (col13 < w_eff) && (row13 + 13'd1 >= kr13)
               && (col13 + 13'd1 >= kc13) && (kr13 <= h_eff) && (kc13 <= w_eff);
        m       = cdsb_pkg::recip(st_eff);
        rem_ok  = (({4'b0, qr_reg} * {12'b0, st_eff}) == {4'b0, dr_reg})
               && (({4'b0, qc_reg} * {12'b0, st_eff}) == {4'b0, dc_reg});
    end

    // Line buffer: one word holds a column of the previous rows
    assign lb_addr = LB_AW'(col_cnt_reg);

    always_comb begin
        for (int k = 0; k < MAX_KERNEL - 1; k++) begin
            colv[k] = lb_rdata[k*SW +: SW];
        end
        colv[MAX_KERNEL-1] = sample_reg;
        for (int k = 0; k < MAX_KERNEL - 1; k++) begin
            lb_wdata[k*SW +: SW] = colv[k+1];
        end
    end

    cdsb_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (lb_we),
        .waddr (lb_addr),
        .wdata (lb_wdata),
        .raddr (lb_addr),
        .rdata (lb_rdata)
    );

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        iw_next      = iw_reg;
        ih_next      = ih_reg;
        kr_next      = kr_reg;
        kc_next      = kc_reg;
        st_next      = st_reg;
        bias_next    = bias_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        sample_next  = sample_reg;
        win_next     = win_reg;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        eh_next      = eh_reg;
        ew_next      = ew_reg;
        qr_next      = qr_reg;
        qc_next      = qc_reg;
        qh_next      = qh_reg;
        qw_next      = qw_reg;
        hit_next     = hit_reg;
        s_ready      = 1'b0;
        lb_we        = 1'b0;
        push         = 1'b0;
        coef_wr.we   = 1'b0;
        coef_wr.addr = s_data.coef_index;
        coef_wr.data = s_data.sample;
        cfg_ready    = 1'b1;

        // Configuration writes
        if (cfg_valid) begin
            unique case (cfg_index)
                cdsb_pkg::REG_IMAGE_WIDTH:  iw_next   = cfg_data[10:0];
                cdsb_pkg::REG_IMAGE_HEIGHT: ih_next   = cfg_data[12:0];
                cdsb_pkg::REG_KERNEL_ROWS:  kr_next   = cfg_data[3:0];
                cdsb_pkg::REG_KERNEL_COLS:  kc_next   = cfg_data[3:0];
                cdsb_pkg::REG_STEP_SIZE:    st_next   = cfg_data[3:0];
                cdsb_pkg::REG_BIAS_VALUE:   bias_next = cfg_data[39:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            cdsb_pkg::F_IDLE: begin
                // Coefficient loads wait until no window still needs the kernel
                if (s_data.op == cdsb_pkg::OP_PIXEL) begin
                    s_ready = !q_full;
                end else begin
                    s_ready = q_empty && !back_busy;
                end
                if (s_valid && s_ready) begin
                    if (s_data.op == cdsb_pkg::OP_PIXEL) begin
                        sample_next = s_data.sample;
                        state_next  = cdsb_pkg::F_RD;
                    end else begin
                        coef_wr.we = 1'b1;
                    end
                end
            end
            cdsb_pkg::F_RD: begin
                // Shift window, write back line buffer, advance counters
                lb_we = 1'b1;
                for (int r = 0; r < MAX_KERNEL; r++) begin
                    for (int c = 0; c < MAX_KERNEL - 1; c++) begin
                        win_next[r][c] = win_reg[r][c+1];
                    end
                    win_next[r][MAX_KERNEL-1] = colv[r];
                end
                hit_next = cond;
                dr_next  = dr13[11:0];
                dc_next  = dc13[11:0];
                eh_next  = eh13[11:0];
                ew_next  = ew13[11:0];
                if (col_inc >= w_eff) begin
                    col_cnt_next = '0;
                    row_cnt_next = (row_inc >= h_eff) ? '0 : row_inc[11:0];
                end else begin
                    col_cnt_next = col_inc[9:0];
                end
                state_next = cdsb_pkg::F_DIV;
            end
            cdsb_pkg::F_DIV: begin
                // Divide by stride through the reciprocal table
                qr_next = 12'(({17'b0, dr_reg} * {12'b0, m}) >> cdsb_pkg::RECIP_SH);
                qc_next = 12'(({17'b0, dc_reg} * {12'b0, m}) >> cdsb_pkg::RECIP_SH);
                qh_next = 12'(({17'b0, eh_reg} * {12'b0, m}) >> cdsb_pkg::RECIP_SH);
                qw_next = 12'(({17'b0, ew_reg} * {12'b0, m}) >> cdsb_pkg::RECIP_SH);
                state_next = cdsb_pkg::F_CHK;
            end
            cdsb_pkg::F_CHK: begin
                // Emit a job when the window sits on the stride grid
                push       = hit_reg && rem_ok;
                state_next = cdsb_pkg::F_IDLE;
            end
            default: state_next = cdsb_pkg::F_IDLE;
        endcase
    end

    assign push_meta.out_row = qr_reg;
    assign push_meta.out_col = qc_reg[9:0];
    assign push_meta.last    = (qr_reg == qh_reg) && (qc_reg == qw_reg);
    assign push_win          = win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdsb_pkg::F_IDLE;
            iw_reg      <= 11'd1024;
            ih_reg      <= 13'd1024;
            kr_reg      <= 4'd3;
            kc_reg      <= 4'd3;
            st_reg      <= 4'd1;
            bias_reg    <= '0;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            win_reg     <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iw_reg      <= iw_next;
            ih_reg      <= ih_next;
            kr_reg      <= kr_next;
            kc_reg      <= kc_next;
            st_reg      <= st_next;
            bias_reg    <= bias_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            win_reg     <= win_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        dr_reg     <= dr_next;
        dc_reg     <= dc_next;
        eh_reg     <= eh_next;
        ew_reg     <= ew_next;
        qr_reg     <= qr_next;
        qc_reg     <= qc_next;
        qh_reg     <= qh_next;
        qw_reg     <= qw_next;
    end

endmodule

FILE: hdl/cdsb_back.sv
module cdsb_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  cdsb_pkg::kcfg_t                        kcfg,
    input  logic                                   q_empty,
    input  cdsb_pkg::job_meta_t                    head_meta,
    input  logic [cdsb_pkg::WIN_W-1:0]             head_win,
    output logic                                   pop,
    output logic                                   back_busy,
    output logic [cdsb_pkg::COEF_AW-1:0]           coef_raddr,
    input  logic [cdsb_pkg::SAMPLE_W-1:0]          coef_rdata,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output cdsb_pkg::out_item_t                    m_data
);

    localparam int MAX_KERNEL = cdsb_pkg::MAX_KERNEL;
    localparam int SW   = cdsb_pkg::SAMPLE_W;
    localparam int KI_W = $clog2(MAX_KERNEL);
    localparam logic [4:0] MK5 = 5'(MAX_KERNEL);

    cdsb_pkg::back_state_t state_reg, state_next;

    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SW-1:0] win_reg, win_next;
    cdsb_pkg::job_meta_t meta_reg, meta_next;
    logic [3:0] k_reg, k_next, l_reg, l_next;
    logic [cdsb_pkg::COEF_AW-1:0] idx_reg, idx_next;
    logic v1_reg, v1_next, v2_reg, v2_next;
    logic signed [SW-1:0]   pix1_reg, pix1_next;
    logic signed [2*SW-1:0] prod_reg;
    logic signed [cdsb_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic m_valid_reg, m_valid_next;
    cdsb_pkg::out_item_t m_data_reg, m_data_next;

    logic [4:0] rsel5, csel5;
    logic [KI_W-1:0] r_idx, c_idx;
    logic signed [cdsb_pkg::ACC_W-1:0] sat;

    assign back_busy  = (state_reg != cdsb_pkg::B_IDLE);
    assign coef_raddr = idx_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Select the window tap for the current kernel position
    always_comb begin
        rsel5 = MK5 - {1'b0, kcfg.kr} + {1'b0, k_reg};
        csel5 = MK5 - {1'b0, kcfg.kc} + {1'b0, l_reg};
        r_idx = rsel5[KI_W-1:0];
        c_idx = csel5[KI_W-1:0];
        if (acc_reg > cdsb_pkg::SUM_MAX) begin
            sat = cdsb_pkg::SUM_MAX;
        end else if (acc_reg < cdsb_pkg::SUM_MIN) begin
            sat = cdsb_pkg::SUM_MIN;
        end else begin
            sat = acc_reg;
        end
    end

    // Sequencer over the kernel, multiply and accumulate
    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        meta_next    = meta_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        idx_next     = idx_reg;
        v1_next      = 1'b0;
        v2_next      = v1_reg;
        pix1_next    = pix1_reg;
        acc_next     = v2_reg ? acc_reg + cdsb_pkg::ACC_W'(prod_reg) : acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pop          = 1'b0;

        unique case (state_reg)
            cdsb_pkg::B_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    win_next   = head_win;
                    meta_next  = head_meta;
                    k_next     = '0;
                    l_next     = '0;
                    idx_next   = '0;
                    acc_next   = cdsb_pkg::ACC_W'(kcfg.bias);
                    state_next = cdsb_pkg::B_RUN;
                end
            end
            cdsb_pkg::B_RUN: begin
                v1_next   = 1'b1;
                pix1_next = win_reg[r_idx][c_idx];
                idx_next  = idx_reg + 1'b1;
                if (l_reg == kcfg.kc - 4'd1) begin
                    l_next = '0;
                    if (k_reg == kcfg.kr - 4'd1) begin
                        state_next = cdsb_pkg::B_DRAIN;
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end else begin
                    l_next = l_reg + 4'd1;
                end
            end
            cdsb_pkg::B_DRAIN: begin
                // Hand the saturated sum to the output register once it is free
                if (!v1_reg && !v2_reg && (!m_valid_reg || m_ready)) begin
                    m_valid_next         = 1'b1;
                    m_data_next.conv_sum = sat[cdsb_pkg::SUM_W-1:0];
                    m_data_next.out_row  = meta_reg.out_row;
                    m_data_next.out_col  = meta_reg.out_col;
                    m_data_next.last     = meta_reg.last;
                    state_next           = cdsb_pkg::B_IDLE;
                end
            end
            default: state_next = cdsb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cdsb_pkg::B_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        meta_reg   <= meta_next;
        k_reg      <= k_next;
        l_reg      <= l_next;
        idx_reg    <= idx_next;
        pix1_reg   <= pix1_next;
        prod_reg   <= $signed(coef_rdata) * pix1_reg;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: dv/conv2d_stride_bias_stream_top_test.sv
`timescale 1ns / 1ps

module conv2d_stride_bias_stream_top_test;

    localparam int MAX_W    = cdsb_pkg::MAX_WIDTH;
    localparam int MAX_K    = cdsb_pkg::MAX_KERNEL;
    localparam int DRAIN_CY = 120;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cdsb_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    cdsb_pkg::out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cdsb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cdsb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    conv2d_stride_bias_stream_top i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // Shadow registers and state of the convolution
    int unsigned img_w = 1024, img_h = 1024, ker_r = 3, ker_c = 3, stride = 1;
    logic signed [cdsb_pkg::SUM_W-1:0] bias_reg = '0;
    logic signed [cdsb_pkg::SAMPLE_W-1:0] kernel_mem [cdsb_pkg::COEF_DEPTH];
    logic signed [cdsb_pkg::SAMPLE_W-1:0] line_mem [MAX_K-1][MAX_W];
    logic signed [cdsb_pkg::SAMPLE_W-1:0] win [MAX_K][MAX_K];
    int unsigned row_cnt = 0, col_cnt = 0;

    cdsb_pkg::in_item_t  pend_q [$];
    cdsb_pkg::out_item_t conv_q [$];
    int errors = 0;
    int gap_left = 0;
    bit no_gaps = 0;
    int stall_left = 0;
    int hold_cnt = 0;
    int hold_req = 0, hold_seen = 0;
    int pixels_sent = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int unsigned clampu(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Compute the result of one pixel transaction and advance the counters
    function automatic void conv_pixel(input logic signed [cdsb_pkg::SAMPLE_W-1:0] s,
                                       output bit hit, output cdsb_pkg::out_item_t res);
        int unsigned w, h, kr, kc, st, row, col, dr, dc, oi, oj, oh, ow;
        logic signed [cdsb_pkg::SAMPLE_W-1:0] colv [MAX_K];
        longint acc;
        w = clampu(img_w, MAX_W);
        h = clampu(img_h, 4096);
        kr = clampu(ker_r, MAX_K);
        kc = clampu(ker_c, MAX_K);
        st = (stride == 0) ? 1 : stride;
        row = row_cnt;
        col = col_cnt;
        hit = 0;
        res = '0;
        for (int k = 0; k < MAX_K - 1; k++) colv[k] = line_mem[k][col % MAX_W];
        colv[MAX_K-1] = s;
        for (int k = 0; k < MAX_K - 1; k++) line_mem[k][col % MAX_W] = colv[k+1];
        for (int r = 0; r < MAX_K; r++) begin
            for (int c = 0; c < MAX_K - 1; c++) win[r][c] = win[r][c+1];
            win[r][MAX_K-1] = colv[r];
        end
        if (row < h && col < w && row + 1 >= kr && col + 1 >= kc && kr <= h && kc <= w) begin
            dr = row + 1 - kr;
            dc = col + 1 - kc;
            if (dr % st == 0 && dc % st == 0) begin
                oi = dr / st;
                oj = dc / st;
                oh = (h - kr) / st + 1;
                ow = (w - kc) / st + 1;
                acc = longint'(bias_reg);
                for (int k = 0; k < kr; k++)
                    for (int l = 0; l < kc; l++)
                        acc += longint'(kernel_mem[(k * kc + l) % cdsb_pkg::COEF_DEPTH]) *
                               longint'(win[MAX_K-kr+k][MAX_K-kc+l]);
                if (acc > longint'(cdsb_pkg::SUM_MAX)) acc = longint'(cdsb_pkg::SUM_MAX);
                if (acc < longint'(cdsb_pkg::SUM_MIN)) acc = longint'(cdsb_pkg::SUM_MIN);
                res.conv_sum = acc[cdsb_pkg::SUM_W-1:0];
                res.out_row = oi[cdsb_pkg::ROW_W-1:0];
                res.out_col = oj[cdsb_pkg::COL_W-1:0];
                res.last = (oi + 1 == oh && oj + 1 == ow);
                hit = 1;
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        row_cnt = row % 4096;
        col_cnt = col % 1024;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Driver: predict on each accepted transaction, then offer the next one
    logic nxt_valid;
    bit hit_d;
    cdsb_pkg::out_item_t res_d;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.op == cdsb_pkg::OP_COEF) begin
                    kernel_mem[s_data.coef_index] = s_data.sample;
                end else begin
                    conv_pixel(s_data.sample, hit_d, res_d);
                    if (hit_d) conv_q.push_back(res_d);
                end
            end
            nxt_valid = s_valid;
            if (!s_valid || s_ready) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    s_data <= pend_q.pop_front();
                    gap_left = (no_gaps || $urandom_range(0, 9) < 5) ? 0 : pick_gap();
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Monitor: stall at random, check each result against the oldest expectation
    logic nxt_ready;
    cdsb_pkg::out_item_t exp_r;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (conv_q.size() == 0) begin
                    report($sformatf("unexpected result %p", m_data));
                end else begin
                    exp_r = conv_q.pop_front();
                    if (m_data.conv_sum !== exp_r.conv_sum)
                        report($sformatf("conv_sum %0d, expected %0d",
                                         m_data.conv_sum, exp_r.conv_sum));
                    if (m_data.out_row !== exp_r.out_row)
                        report($sformatf("out_row %0d, expected %0d",
                                         m_data.out_row, exp_r.out_row));
                    if (m_data.out_col !== exp_r.out_col)
                        report($sformatf("out_col %0d, expected %0d",
                                         m_data.out_col, exp_r.out_col));
                    if (m_data.last !== exp_r.last)
                        report($sformatf("last %0b, expected %0b at %0d,%0d",
                                         m_data.last, exp_r.last,
                                         exp_r.out_row, exp_r.out_col));
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
                if (!no_gaps && $urandom_range(0, 9) < 3) stall_left = pick_gap();
            end
            m_ready <= nxt_ready;
        end
    end

    // Timeout
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(input logic [cdsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdsb_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cdsb_pkg::REG_IMAGE_WIDTH:  img_w = 32'(val[10:0]);
            cdsb_pkg::REG_IMAGE_HEIGHT: img_h = 32'(val[12:0]);
            cdsb_pkg::REG_KERNEL_ROWS:  ker_r = 32'(val[3:0]);
            cdsb_pkg::REG_KERNEL_COLS:  ker_c = 32'(val[3:0]);
            cdsb_pkg::REG_STEP_SIZE:    stride = 32'(val[3:0]);
            cdsb_pkg::REG_BIAS_VALUE:   bias_reg = val[39:0];
            default: ;
        endcase
    endtask

    task automatic setup(input int w, input int h, input int kr, input int kc,
                         input int st, input logic [39:0] b);
        write_reg(cdsb_pkg::REG_IMAGE_WIDTH, 40'(w));
        write_reg(cdsb_pkg::REG_IMAGE_HEIGHT, 40'(h));
        write_reg(cdsb_pkg::REG_KERNEL_ROWS, 40'(kr));
        write_reg(cdsb_pkg::REG_KERNEL_COLS, 40'(kc));
        write_reg(cdsb_pkg::REG_STEP_SIZE, 40'(st));
        write_reg(cdsb_pkg::REG_BIAS_VALUE, b);
    endtask

    // Hold until the block has drained every expected result
    task automatic wait_idle();
        do begin
            do @(posedge aclk); while (pend_q.size() > 0 || s_valid || conv_q.size() > 0);
            repeat (DRAIN_CY) @(posedge aclk);
        end while (pend_q.size() > 0 || s_valid || conv_q.size() > 0);
    endtask

    task automatic push_coef(input int idx, input logic [15:0] val);
        cdsb_pkg::in_item_t it;
        it.op = cdsb_pkg::OP_COEF;
        it.coef_index = idx[cdsb_pkg::COEF_AW-1:0];
        it.sample = val;
        pend_q.push_back(it);
    endtask

    // Push whole frames of pixels so the counters end at the frame start;
    // fix >= 0 gives a constant sample, otherwise random with extremes
    task automatic push_frame(input int fix, input logic [15:0] val, input bit mix_coefs);
        cdsb_pkg::in_item_t it;
        int n;
        int unsigned rnd;
        n = clampu(img_w, MAX_W) * clampu(img_h, 4096);
        for (int i = 0; i < n; i++) begin
            if (mix_coefs && $urandom_range(0, 99) < 3)
                push_coef($urandom_range(0, 63), 16'($urandom));
            rnd = $urandom;
            it.op = cdsb_pkg::OP_PIXEL;
            it.coef_index = rnd[cdsb_pkg::COEF_AW-1:0];
            if (fix >= 0) it.sample = val;
            else if ($urandom_range(0, 19) == 0)
                it.sample = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            else it.sample = rnd[31:16];
            pend_q.push_back(it);
        end
        pixels_sent += n;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the kernel store, all positions at the positive extreme
        for (int i = 0; i < cdsb_pkg::COEF_DEPTH; i++) push_coef(i, 16'h7fff);
        wait_idle();

        // Saturate high, then low
        setup(4, 3, 2, 2, 1, 40'h7f_ffff_ffff);
        push_frame(1, 16'h7fff, 0);
        wait_idle();
        setup(4, 3, 2, 2, 1, 40'h80_0000_0000);
        push_frame(1, 16'h8000, 0);
        wait_idle();

        // Random kernel, with both extremes
        push_coef(0, 16'h8000);
        push_coef(63, 16'h7fff);
        for (int i = 1; i < 63; i++) push_coef(i, 16'($urandom));
        wait_idle();

        // Zero registers act as one
        setup(0, 0, 0, 0, 0, '0);
        push_frame(-1, 0, 0);
        wait_idle();
        // Oversized kernel saturates, with the widest stride
        setup(8, 8, 15, 15, 15, 40'({$urandom, $urandom}));
        push_frame(-1, 0, 0);
        wait_idle();
        // Kernel taller than the image gives nothing
        setup(5, 2, 3, 2, 1, '0);
        push_frame(-1, 0, 0);
        wait_idle();
        // Wide row, widest stride
        setup(200, 1, 1, 1, 15, 40'h00_0000_0100);
        push_frame(-1, 0, 1);
        wait_idle();
        // Tall frame, narrow image
        setup(1, 200, 8, 1, 8, '0);
        no_gaps = 1;
        push_frame(-1, 0, 0);
        wait_idle();
        pixels_sent = 0;

        // Random phases
        for (int ph = 0; pixels_sent < 600; ph++) begin
            logic [39:0] b;
            int w, h, kr, kc, st;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            kr = $urandom_range(1, 8);
            kc = $urandom_range(1, 8);
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
            case ($urandom_range(0, 5))
                0: b = 40'h7f_ffff_ffff;
                1: b = 40'h80_0000_0000;
                default: b = 40'({$urandom, $urandom});
            endcase
            // Dense frame for the long receiver hold
            if (ph == 1) begin
                w = 16;
                h = 10;
                kr = 2;
                kc = 2;
                st = 1;
            end
            setup(w, h, kr, kc, st, b);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                no_gaps = 1;
                hold_req++;
            end
            push_frame(-1, 0, 1);
            // Pause the sender until the block has drained
            wait_idle();
        end

        wait_idle();
        if (errors == 0 && conv_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: conv2d_stride_bias_stream_top.f
hdl/cdsb_pkg.sv
hdl/cdsb_ram.sv
hdl/cdsb_queue.sv
hdl/cdsb_front.sv
hdl/cdsb_back.sv
hdl/conv2d_stride_bias_stream_top.sv
dv/conv2d_stride_bias_stream_top_test.sv
